// File: rtl/stpr_pkg.sv
// Package for the string-to-unsigned parser.
// Holds the transfer payload types, parse state, character codes and
// character classification functions. No dependencies.
`default_nettype none

package stpr_pkg;

	localparam int OffsetBits = 16;
	localparam int ValueBits  = 64;
	localparam int RadixBits  = 6;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7A;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;

	localparam logic [RadixBits-1:0] NoDigit    = 6'd63;
	localparam logic [RadixBits-1:0] RadixAuto  = 6'd0;
	localparam logic [RadixBits-1:0] RadixBad   = 6'd1;
	localparam logic [RadixBits-1:0] RadixOct   = 6'd8;
	localparam logic [RadixBits-1:0] RadixDec   = 6'd10;
	localparam logic [RadixBits-1:0] RadixHex   = 6'd16;
	localparam logic [RadixBits-1:0] RadixMax   = 6'd36;
	localparam logic [RadixBits-1:0] RadixReset = 6'd10;

	typedef logic [RadixBits-1:0] radix_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_START  = 3'd1,
		PH_SIGNED = 3'd2,
		PH_ZERO   = 3'd3,
		PH_PREFIX = 3'd4,
		PH_DIGITS = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_byte;
	} char_item_t;

	typedef struct packed {
		logic [ValueBits-1:0]  value;
		logic                  overflowed;
		logic                  digits_seen;
		logic [OffsetBits-1:0] end_offset;
	} result_item_t;

	typedef struct packed {
		phase_t                phase;
		logic [ValueBits-1:0]  acc;
		radix_t                base;
		logic                  minus;
		logic                  digit;
		logic                  ovf;
		logic [OffsetBits-1:0] pos;
	} parse_state_t;

	function automatic radix_t digit_value(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= ChZero && c <= ChNine) begin
				t = c - ChZero;
			end else if (c >= ChLowA && c <= ChLowZ) begin
				t = c - ChLowA + 8'd10;
			end else if (c >= ChUpA && c <= ChUpZ) begin
				t = c - ChUpA + 8'd10;
			end else begin
				t = {2'b00, NoDigit};
			end
			digit_value = t[RadixBits-1:0];
		end
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == ChSpace) || (c >= ChTab && c <= ChCr);
	endfunction

endpackage

`default_nettype wire

// File: rtl/stpr_step.sv
// One parse step: next parse state and optional result for one byte.
// Combinational; uses stpr_pkg types, codes and classification functions.
`default_nettype none

module stpr_step (
	input  stpr_pkg::parse_state_t st,
	input  stpr_pkg::radix_t       radix,
	input  stpr_pkg::char_item_t   item,
	output stpr_pkg::parse_state_t nst,
	output logic                   emit,
	output stpr_pkg::result_item_t res
);

	localparam logic [stpr_pkg::OffsetBits-1:0] PosMax = '1;
	localparam int ProdBits = stpr_pkg::ValueBits + stpr_pkg::RadixBits;

	logic [7:0]                        c;
	stpr_pkg::radix_t                  d;
	logic                              chk;
	logic                              ok;
	logic                              fin;
	logic [stpr_pkg::OffsetBits-1:0]   fin_end;
	logic [ProdBits-1:0]               prod;

	always_comb begin
		c       = item.char_code;
		d       = stpr_pkg::digit_value(c);
		nst     = st;
		emit    = 1'b0;
		chk     = 1'b0;
		ok      = 1'b0;
		fin     = 1'b0;
		fin_end = st.pos;
		prod    = '0;
		res     = '0;

		if (item.first_byte) begin
			nst.phase = stpr_pkg::PH_START;
			nst.acc   = '0;
			nst.minus = 1'b0;
			nst.digit = 1'b0;
			nst.ovf   = 1'b0;
			nst.pos   = '0;
			if (radix == stpr_pkg::RadixBad || radix > stpr_pkg::RadixMax) begin
				nst.base = stpr_pkg::RadixBad;
			end else begin
				nst.base = radix;
			end
		end else if (st.phase != stpr_pkg::PH_IDLE && st.pos != PosMax) begin
			nst.pos = st.pos + 1'b1;
		end

		if (item.first_byte || st.phase != stpr_pkg::PH_IDLE) begin
			case (nst.phase)
				stpr_pkg::PH_START, stpr_pkg::PH_SIGNED: begin
					if (nst.phase == stpr_pkg::PH_START && stpr_pkg::is_space(c)) begin
						// skip whitespace
					end else if (nst.phase == stpr_pkg::PH_START && c == stpr_pkg::ChMinus) begin
						nst.minus = 1'b1;
						nst.phase = stpr_pkg::PH_SIGNED;
					end else if (nst.phase == stpr_pkg::PH_START && c == stpr_pkg::ChPlus) begin
						nst.phase = stpr_pkg::PH_SIGNED;
					end else if ((nst.base == stpr_pkg::RadixAuto ||
							nst.base == stpr_pkg::RadixHex) && c == stpr_pkg::ChZero) begin
						nst.digit = 1'b1;
						nst.phase = stpr_pkg::PH_ZERO;
					end else begin
						if (nst.base == stpr_pkg::RadixAuto) begin
							nst.base = stpr_pkg::RadixDec;
						end
						nst.phase = stpr_pkg::PH_DIGITS;
						chk = 1'b1;
					end
				end
				stpr_pkg::PH_ZERO: begin
					if (c == stpr_pkg::ChLowX || c == stpr_pkg::ChUpX) begin
						nst.base  = stpr_pkg::RadixHex;
						nst.phase = stpr_pkg::PH_PREFIX;
					end else begin
						if (nst.base == stpr_pkg::RadixAuto) begin
							nst.base = stpr_pkg::RadixOct;
						end
						nst.phase = stpr_pkg::PH_DIGITS;
						chk = 1'b1;
					end
				end
				stpr_pkg::PH_PREFIX: begin
					nst.phase = stpr_pkg::PH_DIGITS;
					chk = 1'b1;
					// the '0' alone is the subject: end at the 'x'
					fin_end = (nst.pos == PosMax) ? nst.pos : nst.pos - 1'b1;
				end
				stpr_pkg::PH_DIGITS: begin
					chk = 1'b1;
					fin_end = nst.pos;
				end
				default: begin
					nst.phase = stpr_pkg::PH_IDLE;
				end
			endcase
			if (nst.phase != stpr_pkg::PH_PREFIX && st.phase != stpr_pkg::PH_PREFIX) begin
				fin_end = nst.pos;
			end
		end

		ok = chk && (nst.base >= 6'd2) && (d < nst.base);
		fin = chk && !ok;

		if (ok) begin
			nst.digit = 1'b1;
			prod = {{stpr_pkg::RadixBits{1'b0}}, nst.acc} *
				{{stpr_pkg::ValueBits{1'b0}}, nst.base} +
				{{stpr_pkg::ValueBits{1'b0}}, d};
			if (!nst.ovf) begin
				if (prod[ProdBits-1:stpr_pkg::ValueBits] != '0) begin
					nst.ovf = 1'b1;
				end else begin
					nst.acc = prod[stpr_pkg::ValueBits-1:0];
				end
			end
		end

		if (fin) begin
			emit = 1'b1;
			if (nst.ovf) begin
				res.value = '1;
			end else if (nst.minus) begin
				res.value = '0 - nst.acc;
			end else begin
				res.value = nst.acc;
			end
			res.overflowed  = nst.ovf;
			res.digits_seen = nst.digit;
			res.end_offset  = nst.digit ? fin_end : '0;
			nst.phase = stpr_pkg::PH_IDLE;
		end
	end

endmodule

`default_nettype wire

// File: rtl/string_to_unsigned_parser.sv
// Top level of the string-to-unsigned parser: radix register, byte input
// register, parse state register and result register around stpr_step.
// Depends on stpr_pkg and stpr_step.
//
// Takes one byte per cycle, back to back. A terminating byte passes the byte input
// register and then the parse step, and the result register loads with result_valid
// as the step fires; the result then waits there until result_ready. A byte holds
// in the input register while an earlier result waits with result_ready low, and
// only then does the input take fewer than one byte per cycle. Each byte passes
// through one parse step whose cost is a 64 by 6 bit multiply and add with an
// overflow test. The radix written on cfg_wdata is sampled at the first byte of
// each string.
`default_nettype none

module string_to_unsigned_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  stpr_pkg::radix_t       cfg_wdata,
	input  logic                   char_valid,
	output logic                   char_ready,
	input  stpr_pkg::char_item_t   char_item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output stpr_pkg::result_item_t result_item
);

	stpr_pkg::radix_t       radix_q;
	stpr_pkg::char_item_t   item_s1;
	logic                   valid_s1;
	stpr_pkg::parse_state_t st_q;
	stpr_pkg::parse_state_t nst;
	logic                   emit;
	stpr_pkg::result_item_t res;
	logic                   fire_s1;

	assign fire_s1    = valid_s1 && (!result_valid || result_ready);
	assign char_ready = !valid_s1 || fire_s1;

	stpr_step u_step (
		.st   (st_q),
		.radix(radix_q),
		.item (item_s1),
		.nst  (nst),
		.emit (emit),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= stpr_pkg::RadixReset;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
			st_q         <= '0;
		end else begin
			if (char_ready) begin
				valid_s1 <= char_valid;
			end
			if (fire_s1) begin
				st_q         <= nst;
				result_valid <= emit;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_item;
		end
		if (fire_s1 && emit) begin
			result_item <= res;
		end
	end

endmodule

`default_nettype wire

// File: test/testbench.sv
// Testbench for string_to_unsigned_parser: random and directed strings in, parse results
// checked against a scoreboard that tracks the parse byte by byte.
// Depends on stpr_pkg and the string_to_unsigned_parser RTL.
`timescale 1ns / 100ps

module testbench;
	import stpr_pkg::*;

	localparam logic [7:0] ChNul = 8'h00;
	localparam longint CycleLimit = 3000000;

	class parse_scoreboard;
		radix_t radix;
		phase_t phase;
		logic [ValueBits-1:0] acc;
		radix_t base;
		logic minus;
		logic digit;
		logic ovf;
		logic [OffsetBits-1:0] pos;
		result_item_t expected_q[$];
		int errors;
		int checked;

		function new();
			radix = RadixReset;
			phase = PH_IDLE;
			acc = '0;
			base = '0;
			minus = 1'b0;
			digit = 1'b0;
			ovf = 1'b0;
			pos = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_radix(radix_t r);
			radix = r;
		endfunction

		function int digit_of(logic [7:0] c);
			if (c >= ChZero && c <= ChNine) begin
				return int'(c) - int'(ChZero);
			end
			if (c >= ChLowA && c <= ChLowZ) begin
				return int'(c) - int'(ChLowA) + 10;
			end
			if (c >= ChUpA && c <= ChUpZ) begin
				return int'(c) - int'(ChUpA) + 10;
			end
			return -1;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == ChSpace || (c >= ChTab && c <= ChCr);
		endfunction

		function bit accepts(int d);
			return d >= 0 && base >= 2 && d < int'(base);
		endfunction

		function void take(int d);
			logic [ValueBits-1:0] b;
			logic [ValueBits-1:0] cutoff;
			logic [ValueBits-1:0] cutlim;
			b = ValueBits'(base);
			cutoff = {ValueBits{1'b1}} / b;
			cutlim = {ValueBits{1'b1}} % b;
			digit = 1'b1;
			if (ovf) begin
				return;
			end
			if (acc > cutoff || (acc == cutoff && ValueBits'(d) > cutlim)) begin
				ovf = 1'b1;
			end else begin
				acc = acc * b + ValueBits'(d);
			end
		endfunction

		function void emit(logic [OffsetBits-1:0] end_pos);
			result_item_t r;
			if (ovf) begin
				r.value = '1;
			end else if (minus) begin
				r.value = '0 - acc;
			end else begin
				r.value = acc;
			end
			r.overflowed = ovf;
			r.digits_seen = digit;
			r.end_offset = digit ? end_pos : '0;
			expected_q.push_back(r);
			phase = PH_IDLE;
		endfunction

		function void lead(logic [7:0] c);
			int d;
			if ((base == RadixAuto || base == RadixHex) && c == ChZero) begin
				digit = 1'b1;
				phase = PH_ZERO;
				return;
			end
			if (base == RadixAuto) begin
				base = RadixDec;
			end
			d = digit_of(c);
			if (accepts(d)) begin
				take(d);
				phase = PH_DIGITS;
			end else begin
				emit(pos);
			end
		endfunction

		function void note_char(char_item_t it);
			logic [7:0] c;
			int d;
			bit tail;
			c = it.char_code;
			tail = 1'b0;
			if (it.first_byte) begin
				phase = PH_START;
				acc = '0;
				minus = 1'b0;
				digit = 1'b0;
				ovf = 1'b0;
				pos = '0;
				base = (radix == RadixBad || radix > RadixMax) ? RadixBad : radix;
			end else begin
				if (phase == PH_IDLE) begin
					return;
				end
				if (pos != '1) begin
					pos = pos + 1'b1;
				end
			end
			case (phase)
			PH_START: begin
				if (is_blank(c)) begin
				end else if (c == ChMinus) begin
					minus = 1'b1;
					phase = PH_SIGNED;
				end else if (c == ChPlus) begin
					phase = PH_SIGNED;
				end else begin
					lead(c);
				end
			end
			PH_SIGNED: begin
				lead(c);
			end
			PH_ZERO: begin
				if (c == ChLowX || c == ChUpX) begin
					base = RadixHex;
					phase = PH_PREFIX;
				end else begin
					if (base == RadixAuto) begin
						base = RadixOct;
					end
					phase = PH_DIGITS;
					tail = 1'b1;
				end
			end
			PH_PREFIX: begin
				d = digit_of(c);
				if (accepts(d)) begin
					take(d);
					phase = PH_DIGITS;
				end else begin
					// the lone zero is the number; end points at the x
					emit(pos == '1 ? pos : pos - 1'b1);
				end
			end
			PH_DIGITS: begin
				tail = 1'b1;
			end
			default: begin
				phase = PH_IDLE;
			end
			endcase
			if (tail) begin
				d = digit_of(c);
				if (accepts(d)) begin
					take(d);
				end else begin
					emit(pos);
				end
			end
		endfunction

		function void check_result(result_item_t got);
			result_item_t exp;
			if (expected_q.size() == 0) begin
				$error("unexpected result: value %h", got.value);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			checked++;
			if (got.value !== exp.value) begin
				$error("value: expected %h, actual %h", exp.value, got.value);
				errors++;
			end
			if (got.overflowed !== exp.overflowed) begin
				$error("overflowed: expected %b, actual %b", exp.overflowed, got.overflowed);
				errors++;
			end
			if (got.digits_seen !== exp.digits_seen) begin
				$error("digits_seen: expected %b, actual %b", exp.digits_seen, got.digits_seen);
				errors++;
			end
			if (got.end_offset !== exp.end_offset) begin
				$error("end_offset: expected %0d, actual %0d", exp.end_offset, got.end_offset);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	radix_t cfg_wdata;
	logic char_valid;
	logic char_ready;
	char_item_t char_item;
	logic result_valid;
	logic result_ready;
	result_item_t result_item;

	parse_scoreboard sb = new();
	int src_idle;
	int sink_idle;
	int chars_sent;
	int strings_sent;
	bit starting;
	radix_t cur_radix;
	longint cycle_count;

	string_to_unsigned_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item(result_item)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				sb.check_result(result_item);
			end
			if (char_valid && char_ready) begin
				sb.note_char(char_item);
			end
		end
	end

	always @(negedge clk) begin
		result_ready = ($urandom_range(0, 99) >= sink_idle);
	end

	task automatic send_char(logic [7:0] c, logic f);
		while ($urandom_range(0, 99) < src_idle) begin
			char_valid = 1'b0;
			@(negedge clk);
		end
		char_item = '{char_code: c, first_byte: f};
		char_valid = 1'b1;
		@(posedge clk);
		while (!char_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic put_byte(logic [7:0] c);
		send_char(c, starting);
		starting = 1'b0;
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			put_byte(s[i]);
		end
	endtask

	task automatic send_str(string s);
		starting = 1'b1;
		put_str(s);
		put_byte(ChNul);
	endtask

	task automatic settle();
		char_valid = 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic write_radix(radix_t r);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = r;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_radix(r);
		cur_radix = r;
	endtask

	function automatic radix_t pick_radix();
		case ($urandom_range(0, 7))
		0: return RadixAuto;
		1: return RadixHex;
		2: return RadixDec;
		3: return RadixOct;
		4: return radix_t'(2);
		5: return RadixMax;
		6: return radix_t'($urandom_range(2, 36));
		default: return radix_t'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) begin
			return 8'(int'(ChZero) + d);
		end
		return 8'(int'($urandom_range(0, 1) ? ChLowA : ChUpA) + d - 10);
	endfunction

	task automatic send_random_string();
		int b;
		int len;
		strings_sent++;
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
			return;
		end
		starting = 1'b1;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3))
				put_byte($urandom_range(0, 1) ? ChSpace : 8'($urandom_range(9, 13)));
		end
		case ($urandom_range(0, 3))
		0: put_byte(ChMinus);
		1: put_byte(ChPlus);
		default: ;
		endcase
		b = (cur_radix == RadixBad || cur_radix > RadixMax) ? 36 : int'(cur_radix);
		if (cur_radix == RadixAuto || cur_radix == RadixHex) begin
			case ($urandom_range(0, 2))
			0: begin
				put_byte(ChZero);
				put_byte($urandom_range(0, 1) ? ChLowX : ChUpX);
				b = 16;
			end
			1: begin
				put_byte(ChZero);
				if (cur_radix == RadixAuto) b = 8;
			end
			default: begin
				if (cur_radix == RadixAuto) b = 10;
			end
			endcase
		end
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
		repeat (len) put_byte(digit_char($urandom_range(0, b - 1)));
		// drop the string unterminated; the next first byte restarts the parse
		if ($urandom_range(0, 19) == 0) begin
			return;
		end
		if ($urandom_range(0, 1) == 0) begin
			put_byte(8'($urandom_range(0, 255)));
		end
		put_byte(ChNul);
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(1, 255)));
		end
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = RadixReset;
		char_valid = 1'b0;
		char_item = '0;
		result_ready = 1'b0;
		src_idle = 10;
		sink_idle = 64;
		chars_sent = 0;
		strings_sent = 0;
		starting = 1'b0;
		cur_radix = RadixReset;
		cycle_count = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		starting = 1'b1;
		for (int c = 9; c <= 13; c++) begin
			put_byte(8'(c));
		end
		put_str(" +42");
		put_byte(ChNul);
		send_str("18446744073709551615");
		send_str("18446744073709551616");
		send_str("-18446744073709551616");
		send_str("-1");
		starting = 1'b1;
		put_str("+x");
		send_str("-");
		send_str("");
		put_str("12");
		starting = 1'b1;
		put_str("123");
		send_str("45");
		starting = 1'b1;
		put_str("7");
		put_byte(8'hFF);

		write_radix(RadixAuto);
		send_str("0x1F");
		starting = 1'b1;
		put_str("0Xg");
		send_str("0777");
		send_str("0");
		send_str("99");
		send_str("0x");
		write_radix(RadixMax);
		send_str("zZ");
		write_radix(RadixHex);
		send_str("0xff");
		send_str("Ab");
		write_radix(radix_t'(2));
		send_str("1012");
		write_radix(RadixBad);
		send_str("  -5");
		write_radix(radix_t'(63));
		send_str("9");

		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 10 : (ph == 1) ? 64 : 0;
			sink_idle = (ph == 0) ? 64 : (ph == 1) ? 10 : 0;
			target = chars_sent + 600;
			while (chars_sent < target) begin
				if (strings_sent % 40 == 0) begin
					write_radix(pick_radix());
				end
				send_random_string();
			end
		end

		settle();
		$display("Sent %0d bytes in %0d random strings plus directed cases; %0d results checked,",
			chars_sent, strings_sent, sb.checked);
		$display("radix 0 to 63, both idling mixes and back to back, %0d mismatches", sb.errors);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/stpr_pkg.sv
rtl/stpr_step.sv
rtl/string_to_unsigned_parser.sv
test/testbench.sv
